// ===== sv/smgd_pkg.sv =====
package smgd_pkg;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned TIMER_W  = 14;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned CFG_W    = 14;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [TIMER_W-1:0]  TIMER_MAX       = 14'd10000;
    localparam logic [COUNT_W-1:0]  COUNT_MAX       = 8'd255;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST   = 12'd2500;
    localparam logic [TIMER_W-1:0]  CONFIRM_RST     = 14'd60;
    localparam logic [COUNT_W-1:0]  LINES_RST       = 8'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINES_TO_FINISH = 2'd2;

    typedef enum logic [1:0] {
        PH_WAIT_FIRST = 2'd0,
        PH_WAIT_CLEAR = 2'd1,
        PH_JUDGE      = 2'd2,
        PH_GOAL       = 2'd3
    } phase_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left_sample;
        logic [SAMPLE_W-1:0] right_sample;
    } in_item_t;

    typedef struct packed {
        logic               left_seen;
        logic               right_seen;
        logic [COUNT_W-1:0] marker_count;
        logic               goal_reached;
    } out_item_t;

    typedef struct packed {
        logic [TIMER_W-1:0] tick_timer;
        phase_t             phase;
        logic               judging;
        logic [COUNT_W-1:0] marker_total;
        logic               goal_done;
    } seq_state_t;

    typedef struct packed {
        logic [TIMER_W-1:0] confirm_ticks;
        logic [COUNT_W-1:0] lines_to_finish;
    } seq_cfg_t;

    function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] total);
        count_up = (total == COUNT_MAX) ? total : total + COUNT_W'(1);
    endfunction

    // Judgement step of phases one and two.
    function automatic seq_state_t judge_step(input seq_state_t s, input logic lf,
                                              input logic rf, input seq_cfg_t cfg);
        seq_state_t n;
        n = s;
        if (lf) begin
            n.judging    = 1'b0;
            n.tick_timer = '0;
        end
        if (!n.judging && rf && (n.tick_timer >= cfg.confirm_ticks)) begin
            n.judging    = 1'b1;
            n.tick_timer = '0;
        end else if (n.judging && (n.tick_timer >= cfg.confirm_ticks)) begin
            n.marker_total = count_up(n.marker_total);
            n.judging      = 1'b0;
            n.tick_timer   = '0;
        end
        if (n.marker_total >= cfg.lines_to_finish) begin
            n.phase = PH_GOAL;
        end
        judge_step = n;
    endfunction

    // One sequencer pass; a pass that changes nothing is a fixed point.
    function automatic seq_state_t seq_pass(input seq_state_t s, input logic lf,
                                            input logic rf, input seq_cfg_t cfg);
        seq_state_t n;
        n = s;
        case (s.phase)
            PH_WAIT_FIRST: begin
                if (rf) begin
                    n.marker_total = count_up(s.marker_total);
                    n.tick_timer   = '0;
                    n.phase        = PH_WAIT_CLEAR;
                end
            end
            PH_WAIT_CLEAR: begin
                if (!rf) begin
                    n.phase = PH_JUDGE;
                end
                n = judge_step(n, lf, rf, cfg);
            end
            PH_JUDGE: begin
                n = judge_step(n, lf, rf, cfg);
            end
            default: begin
                n.goal_done = 1'b1;
            end
        endcase
        seq_pass = n;
    endfunction

endpackage

// ===== sv/smgd_seq.sv =====
module smgd_seq
    import smgd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic       left_flag,
    input  logic       right_flag,
    input  seq_cfg_t   cfg,
    output seq_state_t state_next,
    output seq_state_t state
);

    seq_state_t state_reg;
    seq_state_t tick_state;
    seq_state_t pass1;
    seq_state_t pass2;

    always_comb begin
        tick_state = state_reg;
        tick_state.tick_timer = (state_reg.tick_timer >= TIMER_MAX) ? TIMER_MAX :
                                state_reg.tick_timer + TIMER_W'(1);
    end

    // Three chained passes; once goal_done is set each pass leaves the state alone.
    assign pass1      = seq_pass(tick_state, left_flag, right_flag, cfg);
    assign pass2      = seq_pass(pass1, left_flag, right_flag, cfg);
    assign state_next = seq_pass(pass2, left_flag, right_flag, cfg);
    assign state      = state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{tick_timer: '0, phase: PH_WAIT_FIRST, judging: 1'b0,
                           marker_total: '0, goal_done: 1'b0};
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.goal_done |-> state_reg.phase == PH_GOAL)
        else $error("goal flag set outside goal phase");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.tick_timer <= TIMER_MAX)
        else $error("tick timer above saturation value");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg.marker_total >= $past(state_reg.marker_total))
        else $error("marker count decreased");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(state_reg))
        else $error("sequencer state changed without a transaction");

endmodule

// ===== sv/side_marker_goal_detector.sv =====
// Side-marker goal detector.
// Input channel (s_valid/s_ready/s_data) carries one sensor tick per
// transaction: the left and right side-sensor ADC samples. Result channel
// (m_valid/m_ready/m_data) returns one item per tick: the two line-seen
// flags, the confirmed marker count and the goal flag.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// line threshold, confirm tick count and goal marker count; it is always
// ready and should only be written while no tick is in flight.
// Latency: a result is valid the cycle after its tick is accepted.
// Throughput: one tick per cycle unless a result is stalled; the whole
// state update, including the three chained sequencer passes, sits
// between the state registers and the result register.
// When the receiver stalls, the result register holds and s_ready drops
// only while a result is waiting and m_ready is low.
// Reset: all sequencer state clears, the registers return to threshold
// 2500, confirm ticks 60 and two markers to finish, and no result is valid.
module side_marker_goal_detector
    import smgd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [SAMPLE_W-1:0] threshold_reg;
    logic [TIMER_W-1:0]  confirm_reg;
    logic [COUNT_W-1:0]  lines_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;
    logic                accept;
    logic                left_flag;
    logic                right_flag;
    seq_cfg_t            seq_cfg;
    seq_state_t          state_next;
    seq_state_t          state;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
            confirm_reg   <= CONFIRM_RST;
            lines_reg     <= LINES_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LINE_THRESHOLD:  threshold_reg <= cfg_data[SAMPLE_W-1:0];
                REG_CONFIRM_TICKS:   confirm_reg   <= cfg_data[TIMER_W-1:0];
                REG_LINES_TO_FINISH: lines_reg     <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign left_flag  = s_data.left_sample <= threshold_reg;
    assign right_flag = s_data.right_sample <= threshold_reg;
    assign seq_cfg    = '{confirm_ticks: confirm_reg, lines_to_finish: lines_reg};

    smgd_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .left_flag  (left_flag),
        .right_flag (right_flag),
        .cfg        (seq_cfg),
        .state_next (state_next),
        .state      (state)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= '{left_seen: left_flag, right_seen: right_flag,
                            marker_count: state_next.marker_total,
                            goal_reached: state_next.goal_done};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg && m_data_reg.marker_count == state.marker_total)
        else $error("result count does not match sequencer state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !s_ready)
        else $error("tick taken while a result is stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_data_reg.goal_reached == state.goal_done)
        else $error("result goal flag does not match sequencer state");

endmodule
